FILE: src/modbus_rtu_frame_examiner_core_macros.svh
// Assertion helpers shared by the frame examiner modules.
`ifndef MODBUS_RTU_FRAME_EXAMINER_CORE_MACROS_SVH
`define MODBUS_RTU_FRAME_EXAMINER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define MRFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that must also hold during reset.
`define MRFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/mrfe_pkg.sv
`default_nettype none
package mrfe_pkg;

  // Byte position counter width; covers the largest legal frame limit.
  localparam int POS_W = 8;
  localparam int MAX_FRAME_BYTES_DEF = 255;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Report status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_EXC = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;
  localparam logic [1:0] ST_ERR = 2'd3;

  // Data kinds.
  localparam logic [2:0] DK_NONE    = 3'd0;
  localparam logic [2:0] DK_COIL    = 3'd1;
  localparam logic [2:0] DK_DISC    = 3'd2;
  localparam logic [2:0] DK_HOLDING = 3'd3;
  localparam logic [2:0] DK_INPUT   = 3'd4;

  // Access kinds.
  localparam logic [1:0] AK_NONE  = 2'd0;
  localparam logic [1:0] AK_READ  = 2'd1;
  localparam logic [1:0] AK_WRITE = 2'd2;

  // Function codes.
  localparam logic [7:0] FC_READ_COILS   = 8'd1;
  localparam logic [7:0] FC_READ_DISC    = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS   = 8'd16;
  localparam logic [7:0] FC_MASK_WRITE   = 8'd22;

  localparam logic [POS_W-1:0] EXC_FRAME_LEN = POS_W'(5);
  localparam logic [POS_W-1:0] MIN_FRAME_LEN = POS_W'(4);

  // Undefined field codes.
  localparam logic [8:0]  UNDEF8  = 9'h100;
  localparam logic [16:0] UNDEF16 = 17'h10000;

  // Frame state after the current byte has been taken in.
  typedef struct packed {
    logic [POS_W-1:0] n;
    logic             overlong;
    logic             dir;
    logic [15:0]      crc;
    logic [15:0]      trailer;
    logic [63:0]      hdr;
    logic [15:0]      w0;
    logic [15:0]      w1;
    logic [15:0]      w2;
  } mrfe_snap_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  slave_address;
    logic [8:0]  function_code;
    logic [2:0]  data_kind;
    logic [1:0]  access_kind;
    logic [16:0] start_index;
    logic [16:0] item_count;
    logic [8:0]  exception_code;
    logic [16:0] and_mask;
    logic [16:0] or_mask;
    logic [7:0]  payload_length;
    logic [16:0] computed_crc;
  } mrfe_report_t;

endpackage
`default_nettype wire

FILE: src/mrfe_capture.sv
`default_nettype none
`include "modbus_rtu_frame_examiner_core_macros.svh"
module mrfe_capture #(
  parameter int MAX_FRAME_BYTES = mrfe_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         frame_byte,
  input  wire logic               frame_end,
  input  wire logic               is_response,
  output mrfe_pkg::mrfe_snap_t    snap
);
  import mrfe_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovl_r, ovl_nxt;
  logic             dir_r, dir_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       tr0_r, tr0_nxt;
  logic [7:0]       tr1_r, tr1_nxt;
  logic [63:0]      hdr_r, hdr_nxt;
  logic [15:0]      w0_r, w0_nxt;
  logic [15:0]      w1_r, w1_nxt;
  logic [15:0]      w2_r, w2_nxt;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    pos_nxt = pos_r;
    ovl_nxt = ovl_r;
    crc_nxt = crc_r;
    tr0_nxt = tr0_r;
    tr1_nxt = tr1_r;
    hdr_nxt = hdr_r;
    w0_nxt  = w0_r;
    w1_nxt  = w1_r;
    w2_nxt  = w2_r;
    dir_nxt = ((pos_r == '0) && !ovl_r) ? is_response : dir_r;
    if (ovl_r || (pos_r >= POS_LIMIT)) begin
      ovl_nxt = 1'b1;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (pos_r == POS_W'(k)) begin
          hdr_nxt[8*k +: 8] = frame_byte;
        end
      end
      if (pos_r == POS_W'(3)) begin
        w0_nxt = {hdr_r[23:16], frame_byte};
      end
      if (pos_r == POS_W'(5)) begin
        w1_nxt = {hdr_r[39:32], frame_byte};
      end
      if (pos_r == POS_W'(7)) begin
        w2_nxt = {hdr_r[55:48], frame_byte};
      end
      // The CRC trails the input by two bytes so the trailer never enters it.
      if (pos_r >= POS_W'(2)) begin
        crc_nxt = crc_byte(crc_r, tr0_r);
      end
      tr0_nxt = tr1_r;
      tr1_nxt = frame_byte;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign snap = '{n: pos_nxt, overlong: ovl_nxt, dir: dir_nxt, crc: crc_nxt,
                  trailer: {tr1_nxt, tr0_nxt}, hdr: hdr_nxt,
                  w0: w0_nxt, w1: w1_nxt, w2: w2_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      pos_r <= '0;
      ovl_r <= 1'b0;
      dir_r <= 1'b0;
      crc_r <= CRC_INIT;
      tr0_r <= '0;
      tr1_r <= '0;
      hdr_r <= '0;
      w0_r  <= '0;
      w1_r  <= '0;
      w2_r  <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      ovl_r <= ovl_nxt;
      dir_r <= dir_nxt;
      crc_r <= crc_nxt;
      tr0_r <= tr0_nxt;
      tr1_r <= tr1_nxt;
      hdr_r <= hdr_nxt;
      w0_r  <= w0_nxt;
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
    end
  end

  `MRFE_ASSERT(a_pos_limit, clk, rst_n, pos_r <= POS_LIMIT, "byte position beyond frame limit")
  `MRFE_ASSERT(a_end_clears, clk, rst_n, step && frame_end |=> pos_r == '0 && !ovl_r, "frame state not cleared after frame end")
  `MRFE_ASSERT(a_ovl_at_limit, clk, rst_n, ovl_r |-> pos_r == POS_LIMIT, "overlong flag set below the frame limit")

endmodule
`default_nettype wire

FILE: src/mrfe_report.sv
`default_nettype none
module mrfe_report (
  input  wire mrfe_pkg::mrfe_snap_t snap,
  output mrfe_pkg::mrfe_report_t   rpt
);
  import mrfe_pkg::*;

  logic [7:0] fn;
  logic       known;

  assign fn = snap.hdr[15:8];

  always_comb begin
    rpt = '{status: ST_OK, slave_address: UNDEF8, function_code: UNDEF8,
            data_kind: DK_NONE, access_kind: AK_NONE, start_index: UNDEF16,
            item_count: UNDEF16, exception_code: UNDEF8, and_mask: UNDEF16,
            or_mask: UNDEF16, payload_length: 8'd0, computed_crc: UNDEF16};
    known = 1'b1;
    if (snap.overlong || (snap.n < MIN_FRAME_LEN)) begin
      rpt.status = ST_ERR;
    end else begin
      rpt.computed_crc = {1'b0, snap.crc};
      if (snap.crc != snap.trailer) begin
        rpt.status = ST_CRC;
      end else begin
        rpt.slave_address = {1'b0, snap.hdr[7:0]};
        rpt.function_code = {1'b0, fn};
        unique case ({1'b0, fn[6:0]}) inside
          FC_READ_COILS: begin
            rpt.data_kind = DK_COIL;
            rpt.access_kind = AK_READ;
          end
          FC_READ_DISC: begin
            rpt.data_kind = DK_DISC;
            rpt.access_kind = AK_READ;
          end
          FC_READ_HOLDING: begin
            rpt.data_kind = DK_HOLDING;
            rpt.access_kind = AK_READ;
          end
          FC_READ_INPUT: begin
            rpt.data_kind = DK_INPUT;
            rpt.access_kind = AK_READ;
          end
          FC_WRITE_COIL, FC_WRITE_COILS: begin
            rpt.data_kind = DK_COIL;
            rpt.access_kind = AK_WRITE;
          end
          FC_WRITE_REG, FC_WRITE_REGS, FC_MASK_WRITE: begin
            rpt.data_kind = DK_HOLDING;
            rpt.access_kind = AK_WRITE;
          end
          default: known = 1'b0;
        endcase
        if (!known) begin
          rpt.status = ST_ERR;
        end else if ((snap.n == EXC_FRAME_LEN) && fn[7]) begin
          rpt.status = ST_EXC;
          rpt.exception_code = {1'b0, snap.hdr[23:16]};
        end else begin
          // Requests and responses lay the PDU out differently for reads
          // and multiple writes; single and mask writes echo the same layout.
          unique case (fn) inside
            FC_READ_COILS, FC_READ_DISC, FC_READ_HOLDING, FC_READ_INPUT: begin
              if (!snap.dir) begin
                rpt.start_index = {1'b0, snap.w0};
                rpt.item_count = {1'b0, snap.w1};
              end else begin
                rpt.payload_length = snap.hdr[23:16];
              end
            end
            FC_WRITE_COIL, FC_WRITE_REG: begin
              rpt.start_index = {1'b0, snap.w0};
              rpt.item_count = 17'd1;
              rpt.payload_length = 8'd2;
            end
            FC_WRITE_COILS, FC_WRITE_REGS: begin
              rpt.start_index = {1'b0, snap.w0};
              rpt.item_count = {1'b0, snap.w1};
              if (!snap.dir) begin
                rpt.payload_length = snap.hdr[55:48];
              end
            end
            FC_MASK_WRITE: begin
              rpt.start_index = {1'b0, snap.w0};
              rpt.item_count = 17'd1;
              rpt.and_mask = {1'b0, snap.w1};
              rpt.or_mask = {1'b0, snap.w2};
            end
            default: rpt.status = ST_ERR;
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/modbus_rtu_frame_examiner_core.sv
// A frame's final byte passes the input register; its report is written to the output register once that is free.
// Throughput: one byte per cycle; only a final byte whose report is still held
// in a stalled output register keeps the input from advancing.
// Reset: synchronous, active-low rst_n empties both registers and returns the
// frame state to its start value (position zero, CRC 0xFFFF).
`default_nettype none
`include "modbus_rtu_frame_examiner_core_macros.svh"
module modbus_rtu_frame_examiner_core #(
  parameter int MAX_FRAME_BYTES = mrfe_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_end,
  input  wire logic        in_is_response,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [8:0]       out_slave_address,
  output logic [8:0]       out_function_code,
  output logic [2:0]       out_data_kind,
  output logic [1:0]       out_access_kind,
  output logic [16:0]      out_start_index,
  output logic [16:0]      out_item_count,
  output logic [8:0]       out_exception_code,
  output logic [16:0]      out_and_mask,
  output logic [16:0]      out_or_mask,
  output logic [7:0]       out_payload_length,
  output logic [16:0]      out_computed_crc
);
  import mrfe_pkg::*;

  // Input register: one request from the byte channel.
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_resp_r;

  // Output register holding one frame report.
  logic         out_valid_r;
  mrfe_report_t out_rpt_r;

  mrfe_snap_t   snap;
  mrfe_report_t rpt;

  logic out_free;
  logic s1_go;

  // A byte in the input register moves on unless it closes a frame whose
  // report cannot be written because the previous report is still waiting.
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_vld_r && (!s1_end_r || out_free);
  assign in_ready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_frame_byte;
      s1_end_r  <= in_frame_end;
      s1_resp_r <= in_is_response;
    end
  end

  // Frame state: position, running CRC, trailer, header bytes and words.
  mrfe_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go),
    .frame_byte  (s1_byte_r),
    .frame_end   (s1_end_r),
    .is_response (s1_resp_r),
    .snap        (snap)
  );

  // Status and field decode of the frame as it stands after this byte.
  mrfe_report u_report (
    .snap (snap),
    .rpt  (rpt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      out_rpt_r <= rpt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_rpt_r.status;
  assign out_slave_address  = out_rpt_r.slave_address;
  assign out_function_code  = out_rpt_r.function_code;
  assign out_data_kind      = out_rpt_r.data_kind;
  assign out_access_kind    = out_rpt_r.access_kind;
  assign out_start_index    = out_rpt_r.start_index;
  assign out_item_count     = out_rpt_r.item_count;
  assign out_exception_code = out_rpt_r.exception_code;
  assign out_and_mask       = out_rpt_r.and_mask;
  assign out_or_mask        = out_rpt_r.or_mask;
  assign out_payload_length = out_rpt_r.payload_length;
  assign out_computed_crc   = out_rpt_r.computed_crc;

  // A fresh report always follows a frame-end byte leaving the input register.
  `MRFE_ASSERT(a_rpt_source, clk, rst_n, out_valid_r && !$past(out_valid_r) |-> $past(s1_vld_r && s1_end_r), "report without a frame end")
  // The input side only stalls behind a held report.
  `MRFE_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> s1_vld_r && s1_end_r && out_valid_r && !out_ready, "input stalled without cause")
  // A good frame always carries a defined address and CRC.
  `MRFE_ASSERT(a_ok_fields, clk, rst_n, out_valid_r && out_status == ST_OK |-> !out_slave_address[8] && !out_computed_crc[16], "ok report with undefined fields")
  // A CRC mismatch hides every field but the computed CRC.
  `MRFE_ASSERT(a_crc_fields, clk, rst_n, out_valid_r && out_status == ST_CRC |-> out_slave_address == UNDEF8 && !out_computed_crc[16], "CRC report field mix")

endmodule
`default_nettype wire

FILE: test/tb_modbus_rtu_frame_examiner_core.sv
`timescale 1ns / 1ps
module tb_modbus_rtu_frame_examiner_core;
  import mrfe_pkg::*;

  localparam int FRAME_LIMIT = MAX_FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [7:0] EXC_BIT = 8'h80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_frame_byte;
  logic        in_frame_end;
  logic        in_is_response;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [8:0]  out_slave_address;
  logic [8:0]  out_function_code;
  logic [2:0]  out_data_kind;
  logic [1:0]  out_access_kind;
  logic [16:0] out_start_index;
  logic [16:0] out_item_count;
  logic [8:0]  out_exception_code;
  logic [16:0] out_and_mask;
  logic [16:0] out_or_mask;
  logic [7:0]  out_payload_length;
  logic [16:0] out_computed_crc;

  modbus_rtu_frame_examiner_core #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_byte     (in_frame_byte),
    .in_frame_end      (in_frame_end),
    .in_is_response    (in_is_response),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slave_address (out_slave_address),
    .out_function_code (out_function_code),
    .out_data_kind     (out_data_kind),
    .out_access_kind   (out_access_kind),
    .out_start_index   (out_start_index),
    .out_item_count    (out_item_count),
    .out_exception_code(out_exception_code),
    .out_and_mask      (out_and_mask),
    .out_or_mask       (out_or_mask),
    .out_payload_length(out_payload_length),
    .out_computed_crc  (out_computed_crc)
  );

  // The nine function codes that the block classifies.
  logic [7:0] known_codes [9] = '{FC_READ_COILS, FC_READ_DISC, FC_READ_HOLDING,
                                  FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG,
                                  FC_WRITE_COILS, FC_WRITE_REGS, FC_MASK_WRITE};

  mrfe_report_t pending_reports[$];
  logic [7:0]   body[$];
  int           mismatch_count = 0;
  int           reports_seen = 0;
  int           bytes_sent = 0;
  int           cycle_count = 0;
  bit           source_gaps = 0;
  bit           sink_stalls = 0;

  // Frame tracker: mirrors the frame state that the block keeps.
  int unsigned fr_len;
  bit          fr_over;
  bit          fr_dir;
  logic [15:0] fr_crc;
  logic [7:0]  fr_trl [2];
  logic [7:0]  fr_hdr [8];
  logic [15:0] fr_word [3];

  always #4 clk = ~clk;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    fr_len = 0;
    fr_over = 1'b0;
    fr_dir = 1'b0;
    fr_crc = CRC_INIT;
    fr_trl = '{8'h00, 8'h00};
    for (int i = 0; i < 8; i++) fr_hdr[i] = 8'h00;
    for (int i = 0; i < 3; i++) fr_word[i] = 16'h0000;
  endfunction

  // Report the block owes for the frame held in the tracker.
  function automatic mrfe_report_t frame_report();
    mrfe_report_t r;
    logic [7:0]   fn;
    r.status         = ST_OK;
    r.slave_address  = UNDEF8;
    r.function_code  = UNDEF8;
    r.data_kind      = DK_NONE;
    r.access_kind    = AK_NONE;
    r.start_index    = UNDEF16;
    r.item_count     = UNDEF16;
    r.exception_code = UNDEF8;
    r.and_mask       = UNDEF16;
    r.or_mask        = UNDEF16;
    r.payload_length = 8'd0;
    r.computed_crc   = UNDEF16;
    if (fr_over || fr_len < MIN_FRAME_LEN) begin
      r.status = ST_ERR;
      return r;
    end
    r.computed_crc = {1'b0, fr_crc};
    if (fr_crc != {fr_trl[1], fr_trl[0]}) begin
      r.status = ST_CRC;
      return r;
    end
    fn = fr_hdr[1];
    r.slave_address = {1'b0, fr_hdr[0]};
    r.function_code = {1'b0, fn};
    case (fn & ~EXC_BIT)
      FC_READ_COILS:   begin r.data_kind = DK_COIL;    r.access_kind = AK_READ; end
      FC_READ_DISC:    begin r.data_kind = DK_DISC;    r.access_kind = AK_READ; end
      FC_READ_HOLDING: begin r.data_kind = DK_HOLDING; r.access_kind = AK_READ; end
      FC_READ_INPUT:   begin r.data_kind = DK_INPUT;   r.access_kind = AK_READ; end
      FC_WRITE_COIL, FC_WRITE_COILS: begin
        r.data_kind = DK_COIL;
        r.access_kind = AK_WRITE;
      end
      FC_WRITE_REG, FC_WRITE_REGS, FC_MASK_WRITE: begin
        r.data_kind = DK_HOLDING;
        r.access_kind = AK_WRITE;
      end
      default: begin
        r.status = ST_ERR;
        return r;
      end
    endcase
    if (fr_len == EXC_FRAME_LEN && (fn & EXC_BIT) != 8'h00) begin
      r.exception_code = {1'b0, fr_hdr[2]};
      r.status = ST_EXC;
      return r;
    end
    // With the exception bit set the code no longer matches any case below.
    case (fn)
      FC_READ_COILS, FC_READ_DISC, FC_READ_HOLDING, FC_READ_INPUT: begin
        if (!fr_dir) begin
          r.start_index = {1'b0, fr_word[0]};
          r.item_count  = {1'b0, fr_word[1]};
        end else begin
          r.payload_length = fr_hdr[2];
        end
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        r.start_index = {1'b0, fr_word[0]};
        r.item_count = 17'd1;
        r.payload_length = 8'd2;
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        r.start_index = {1'b0, fr_word[0]};
        r.item_count  = {1'b0, fr_word[1]};
        if (!fr_dir) r.payload_length = fr_hdr[6];
      end
      FC_MASK_WRITE: begin
        r.start_index = {1'b0, fr_word[0]};
        r.item_count = 17'd1;
        r.and_mask = {1'b0, fr_word[1]};
        r.or_mask  = {1'b0, fr_word[2]};
      end
      default: r.status = ST_ERR;
    endcase
    return r;
  endfunction

  // Takes in one accepted byte; at the frame end the owed report is queued.
  function automatic void absorb_byte(input logic [7:0] b, input logic fend,
                                      input logic resp);
    if (fr_len == 0 && !fr_over) fr_dir = resp;
    if (fr_over || fr_len >= FRAME_LIMIT) begin
      fr_over = 1'b1;
    end else begin
      if (fr_len < 8) begin
        fr_hdr[fr_len] = b;
        if (fr_len == 3 || fr_len == 5 || fr_len == 7)
          fr_word[(fr_len - 3) / 2] = {fr_hdr[fr_len - 1], b};
      end
      if (fr_len >= 2) fr_crc = crc16_byte(fr_crc, fr_trl[0]);
      fr_trl[0] = fr_trl[1];
      fr_trl[1] = b;
      fr_len++;
    end
    if (fend) begin
      pending_reports.push_back(frame_report());
      clear_frame();
    end
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic note_mismatch(input string what, input logic [16:0] got,
                               input logic [16:0] want);
    mismatch_count++;
    $display("report %0d: %s is 0x%0h, expected 0x%0h", reports_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  // One input request per frame byte. The payload changes only at a falling
  // edge and the handshake is judged on the values seen at the rising edge.
  task automatic send_byte(input logic [7:0] b, input logic fend, input logic resp);
    int unsigned gap;
    gap = (source_gaps && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_frame_byte = b;
    in_frame_end = fend;
    in_is_response = resp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b, fend, resp);
    bytes_sent++;
  endtask

  // The direction only counts on the first byte, so the others carry noise.
  task automatic send_raw(input bit resp);
    for (int k = 0; k < body.size(); k++)
      send_byte(body[k], k == body.size() - 1, (k == 0) ? resp : 1'($urandom));
  endtask

  task automatic send_frame(input bit resp, input bit corrupt);
    logic [15:0] crc;
    int unsigned k;
    crc = CRC_INIT;
    for (k = 0; k < body.size(); k++) crc = crc16_byte(crc, body[k]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    // A single flipped bit anywhere is always caught by the CRC.
    if (corrupt) begin
      k = $urandom_range(0, body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_raw(resp);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) body.push_back(8'($urandom));
  endtask

  // Well-formed PDU layout for the given code and direction, random content.
  task automatic build_pdu(input logic [7:0] fn, input bit resp);
    int unsigned cnt;
    body.delete();
    add_random(1);
    body.push_back(fn);
    case (fn)
      FC_READ_COILS, FC_READ_DISC, FC_READ_HOLDING, FC_READ_INPUT: begin
        if (!resp) begin
          add_random(4);
        end else begin
          cnt = $urandom_range(0, 6);
          body.push_back(8'(cnt));
          add_random(cnt);
        end
      end
      FC_WRITE_COIL, FC_WRITE_REG: add_random(4);
      FC_MASK_WRITE: add_random(6);
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        add_random(4);
        if (!resp) begin
          cnt = $urandom_range(0, 6);
          body.push_back(8'(cnt));
          add_random(cnt);
        end
      end
      default: ;
    endcase
  endtask

  // Holds off new requests until every owed report has come out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_short_frames();
    for (int n = 1; n <= 3; n++) begin
      body.delete();
      add_random(n);
      send_raw(n[0]);
    end
  endtask

  task automatic test_function_codes();
    for (int i = 0; i < 9; i++) begin
      build_pdu(known_codes[i], i[0]);
      send_frame(i[0], 1'b0);
    end
  endtask

  task automatic test_exception_frames();
    // Proper five-byte exception reply.
    body = '{8'h11, EXC_BIT | FC_READ_HOLDING, 8'h02};
    send_frame(1'b1, 1'b0);
    // Exception bit set, but one byte too many.
    body = '{8'h11, EXC_BIT | FC_WRITE_REGS, 8'h04, 8'h00};
    send_frame(1'b1, 1'b0);
    // Five bytes with the exception bit on an unknown base code.
    body = '{8'h11, EXC_BIT | 8'h07, 8'h01};
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_crc_mismatch();
    build_pdu(FC_READ_HOLDING, 1'b0);
    send_frame(1'b0, 1'b1);
  endtask

  task automatic test_unknown_functions();
    body = '{8'h01, 8'h00, 8'h12, 8'h34};
    send_frame(1'b0, 1'b0);
    body = '{8'h01, 8'hFF, 8'h12, 8'h34};
    send_frame(1'b1, 1'b0);
  endtask

  // PDU offsets beyond the received bytes read as zero.
  task automatic test_missing_bytes();
    body = '{8'h05, FC_MASK_WRITE, 8'h12, 8'h34};
    send_frame(1'b0, 1'b0);
    body = '{8'h05, FC_READ_INPUT};
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_field_extremes();
    body = '{8'hFF, FC_WRITE_REGS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b0, 1'b0);
    body = '{8'h00, FC_WRITE_REGS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(1'b0, 1'b0);
    body = '{8'hFF, FC_MASK_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b1, 1'b0);
  endtask

  // A frame of exactly the limit passes; one byte more is overlong.
  task automatic test_frame_limits();
    for (int extra = 0; extra <= 1; extra++) begin
      body = '{8'h2A, FC_WRITE_REGS};
      add_random(FRAME_LIMIT - 4 + extra);
      send_frame(1'b0, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_mark;
    int unsigned pick;
    bit          resp;
    start = bytes_sent;
    next_mark = start + 70;
    while (bytes_sent - start < 200) begin
      pick = $urandom_range(0, 99);
      resp = 1'($urandom);
      if (pick < 70) begin
        build_pdu(known_codes[$urandom_range(0, 8)], resp);
        if ($urandom_range(0, 9) == 0) add_random($urandom_range(1, 3));
        send_frame(resp, 1'b0);
      end else if (pick < 80) begin
        body.delete();
        add_random(1);
        body.push_back(known_codes[$urandom_range(0, 8)] | EXC_BIT);
        add_random(1);
        send_frame(resp, 1'b0);
      end else if (pick < 90) begin
        build_pdu(known_codes[$urandom_range(0, 8)], resp);
        send_frame(resp, 1'b1);
      end else begin
        body.delete();
        add_random($urandom_range(1, 10));
        if ($urandom_range(0, 2) == 0) send_frame(resp, 1'b0);
        else send_raw(resp);
      end
      // Middle stretch runs back to back on both sides.
      if (bytes_sent >= next_mark) begin
        drain();
        source_gaps = ~source_gaps;
        sink_stalls = ~sink_stalls;
        next_mark = bytes_sent + 70;
      end
    end
  endtask

  // Result side: random back-pressure on the report channel.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (pause_len()) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_reports
    mrfe_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        note_mismatch("report with no frame pending", 17'd0, 17'd0);
      end else begin
        want = pending_reports.pop_front();
        check_field("status", out_status, want.status);
        check_field("slave_address", out_slave_address, want.slave_address);
        check_field("function_code", out_function_code, want.function_code);
        check_field("data_kind", out_data_kind, want.data_kind);
        check_field("access_kind", out_access_kind, want.access_kind);
        check_field("start_index", out_start_index, want.start_index);
        check_field("item_count", out_item_count, want.item_count);
        check_field("exception_code", out_exception_code, want.exception_code);
        check_field("and_mask", out_and_mask, want.and_mask);
        check_field("or_mask", out_or_mask, want.or_mask);
        check_field("payload_length", out_payload_length, want.payload_length);
        check_field("computed_crc", out_computed_crc, want.computed_crc);
      end
      reports_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[modbus_rtu_frame_examiner_core] ERROR");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_frame_byte = 8'h00;
    in_frame_end = 1'b0;
    in_is_response = 1'b0;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_short_frames();
    test_function_codes();
    test_exception_frames();
    drain();
    test_crc_mismatch();
    test_unknown_functions();
    test_missing_bytes();
    test_field_extremes();
    drain();
    test_frame_limits();
    drain();
    test_random_traffic();
    drain();

    // Every owed report has been checked once the drain returns.
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[modbus_rtu_frame_examiner_core] OK");
    end else begin
      $display("[modbus_rtu_frame_examiner_core] ERROR");
    end
    $finish;
  end

endmodule
